[rtl/mau_pkg.sv]
// Package for the modular arithmetic unit: mode codes, widths, reset modulus.
// No dependencies.
package mau_pkg;
  localparam int unsigned MOD_W_DEF = 31;
  localparam int unsigned OPND_W = 64;
  localparam int unsigned RES_W = 31;
  localparam int unsigned MODE_W = 3;
  localparam logic [63:0] MOD_RESET = 64'd1000000007;

  typedef enum logic [MODE_W-1:0] {
    MODE_REDUCE = 3'd0,
    MODE_ADD    = 3'd1,
    MODE_SUB    = 3'd2,
    MODE_NEG    = 3'd3,
    MODE_MUL    = 3'd4,
    MODE_DIV    = 3'd5,
    MODE_POW    = 3'd6,
    MODE_NONE   = 3'd7
  } mode_t;
endpackage

[rtl/mau_reduce.sv]
// Bit-serial remainder of a 64-bit magnitude by the modulus, one bit per cycle.
// Depends on mau_pkg.
module mau_reduce #(
  parameter int unsigned MW = mau_pkg::MOD_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mau_pkg::OPND_W-1:0]  mag,
  input  logic [MW-1:0]               m,
  output logic                        done,
  output logic [MW-1:0]               rem
);
  import mau_pkg::*;
  localparam int unsigned CW = $clog2(OPND_W + 1);

  logic [OPND_W-1:0] sh_r, sh_nxt;
  logic [MW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              run_r, run_nxt, done_r, done_nxt;
  logic [MW:0]       dbl;

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    dbl      = {rem_r, sh_r[OPND_W-1]};
    if (start) begin
      sh_nxt  = mag;
      rem_nxt = '0;
      cnt_nxt = CW'(OPND_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = (dbl >= {1'b0, m}) ? MW'(dbl - {1'b0, m}) : dbl[MW-1:0];
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r) else $error("reduce done while running");
  a_rem_rng: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < m)) else $error("reduce remainder out of range");
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> run_r) else $error("reduce did not start");
endmodule

[rtl/mau_mulmod.sv]
// Bit-serial modular multiply: shift-and-add over the bits of b, one per cycle.
// Depends on mau_pkg.
module mau_mulmod #(
  parameter int unsigned MW = mau_pkg::MOD_W_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [MW-1:0] a,
  input  logic [MW-1:0] b,
  input  logic [MW-1:0] m,
  output logic          done,
  output logic [MW-1:0] prod
);
  import mau_pkg::*;
  localparam int unsigned CW = $clog2(MW + 1);

  logic [MW-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt, done_r, done_nxt;
  logic [MW:0]   s_acc, s_dbl;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    s_acc    = {1'b0, acc_r} + {1'b0, a_r};
    s_dbl    = {1'b0, a_r} + {1'b0, a_r};
    if (start) begin
      a_nxt   = a;
      b_nxt   = b;
      acc_nxt = '0;
      cnt_nxt = CW'(MW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (b_r[0]) begin
        acc_nxt = (s_acc >= {1'b0, m}) ? MW'(s_acc - {1'b0, m}) : s_acc[MW-1:0];
      end
      a_nxt   = (s_dbl >= {1'b0, m}) ? MW'(s_dbl - {1'b0, m}) : s_dbl[MW-1:0];
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r) else $error("mulmod done while running");
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> run_r) else $error("mulmod did not start");
  a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == '0)) else $error("mulmod count left over");
endmodule

[rtl/modular_arithmetic_unit.sv]
// Top level of the modular arithmetic unit: sequencer over a bit-serial
// reducer and a bit-serial modular multiplier. Depends on mau_pkg,
// mau_reduce and mau_mulmod.
//
// Usage:
//  - Write the modulus on cfg_we/cfg_wdata while idle; reset loads 1000000007.
//    A modulus of zero acts as one. Bits above MODULUS_WIDTH are dropped.
//  - A request is taken when in_start is high and in_busy is low. in_busy
//    stays high until the cycle after the result is shown.
//  - The result appears on out_result for one cycle with out_valid high.
//    The receiver cannot stall; nothing waits on it.
// Sequence: both operands are reduced in turn through the bit-serial
// remainder of their 64-bit magnitudes. Reduce/add/sub/negate then finish
// in the evaluate state and show the result in the output state.
// A multiply runs in the shift-and-add unit, one bit of b at a time.
// Pow runs one or two multiplies per exponent bit, up to 63 bits, so up
// to 125 multiplies; divide runs MODULUS_WIDTH exponent bits plus one
// multiply.
// One request is in flight at a time; no new one is taken until the result is shown.
// Reset returns the sequencer to idle and drops any request in progress.
module modular_arithmetic_unit #(
  parameter int unsigned MODULUS_WIDTH = mau_pkg::MOD_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mau_pkg::RES_W-1:0]         cfg_wdata,
  input  logic                              in_start,
  output logic                              in_busy,
  input  logic [mau_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [mau_pkg::OPND_W-1:0] in_operand_a,
  input  logic signed [mau_pkg::OPND_W-1:0] in_operand_b,
  output logic                              out_valid,
  output logic [mau_pkg::RES_W-1:0]         out_result
);
  import mau_pkg::*;
  localparam int unsigned MW = MODULUS_WIDTH;
  localparam int unsigned EW = OPND_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RED_A = 9'b000000010,
    S_RED_B = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_PMUL  = 9'b000010000,
    S_PSQR  = 9'b000100000,
    S_FMUL  = 9'b001000000,
    S_WAIT  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t        st_r, st_nxt;
  logic [MW-1:0] mod_r;
  logic [MW-1:0] m;
  mode_t         mode_r;
  logic [EW-1:0] b_raw_r;
  logic [MW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [MW-1:0] acc_r, acc_nxt, base_r, base_nxt, res_r, res_nxt;
  logic [EW-1:0] exp_r, exp_nxt;
  logic          red_start, mul_start, red_done, mul_done;
  logic [EW-1:0] red_mag;
  logic [MW-1:0] red_rem, mul_a, mul_b, mul_p;
  logic          neg_r, neg_nxt;
  logic [MW:0]   sum;
  logic [MW-1:0] one_m, fixed_rem;
  state_t        ret_r, ret_nxt;

  // Modulus register; zero acts as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MW'(MOD_RESET);
    end else if (cfg_we) begin
      mod_r <= MW'(cfg_wdata);
    end
  end
  assign m     = (mod_r == '0) ? MW'(1) : mod_r;
  assign one_m = (m == MW'(1)) ? '0 : MW'(1);

  mau_reduce #(.MW(MW)) u_red (
    .clk(clk), .rst_n(rst_n), .start(red_start), .mag(red_mag), .m(m),
    .done(red_done), .rem(red_rem)
  );
  mau_mulmod #(.MW(MW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b), .m(m),
    .done(mul_done), .prod(mul_p)
  );

  // Negative inputs: reduce |x|, then m - r when r is nonzero.
  assign fixed_rem = (neg_r && red_rem != '0) ? MW'(m - red_rem) : red_rem;
  assign sum       = {1'b0, a_r} + {1'b0, b_r};

  always_comb begin
    st_nxt    = st_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    res_nxt   = res_r;
    neg_nxt   = neg_r;
    ret_nxt   = ret_r;
    red_start = 1'b0;
    red_mag   = '0;
    mul_start = 1'b0;
    mul_a     = acc_r;
    mul_b     = base_r;
    case (st_r)
      S_IDLE: begin
        if (in_start) begin
          red_start = 1'b1;
          red_mag   = in_operand_a[EW-1] ? EW'(-in_operand_a) : in_operand_a;
          neg_nxt   = in_operand_a[EW-1];
          st_nxt    = S_RED_A;
        end
      end
      S_RED_A: begin
        if (red_done) begin
          a_nxt     = fixed_rem;
          red_start = 1'b1;
          red_mag   = b_raw_r[EW-1] ? EW'(-b_raw_r) : b_raw_r;
          neg_nxt   = b_raw_r[EW-1];
          st_nxt    = S_RED_B;
        end
      end
      S_RED_B: begin
        if (red_done) begin
          b_nxt  = fixed_rem;
          st_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        st_nxt = S_OUT;
        case (mode_r)
          MODE_REDUCE: res_nxt = a_r;
          MODE_ADD: res_nxt = (sum >= {1'b0, m}) ? MW'(sum - {1'b0, m})
                                                 : sum[MW-1:0];
          MODE_SUB: res_nxt = (a_r >= b_r) ? MW'(a_r - b_r) : MW'(sum - {1'b0, b_r}
                                + {1'b0, m} - {1'b0, b_r});
          MODE_NEG: res_nxt = (a_r == '0) ? '0 : MW'(m - a_r);
          MODE_MUL: begin
            mul_start = 1'b1;
            mul_a     = a_r;
            mul_b     = b_r;
            ret_nxt   = S_FMUL;
            st_nxt    = S_WAIT;
          end
          MODE_DIV: begin
            acc_nxt  = one_m;
            base_nxt = b_r;
            exp_nxt  = (m > MW'(2)) ? EW'(m - MW'(2)) : '0;
            st_nxt   = S_PMUL;
          end
          MODE_POW: begin
            acc_nxt  = one_m;
            base_nxt = a_r;
            exp_nxt  = b_raw_r[EW-1] ? '0 : b_raw_r;
            st_nxt   = S_PMUL;
          end
          default: res_nxt = '0;
        endcase
      end
      S_PMUL: begin
        // One exponent bit: multiply acc if set, then square base; zero exp ends.
        if (exp_r == '0) begin
          if (mode_r == MODE_DIV) begin
            mul_start = 1'b1;
            mul_a     = a_r;
            mul_b     = acc_r;
            ret_nxt   = S_FMUL;
            st_nxt    = S_WAIT;
          end else begin
            res_nxt = acc_r;
            st_nxt  = S_OUT;
          end
        end else if (exp_r[0]) begin
          mul_start = 1'b1;
          ret_nxt   = S_PMUL;
          st_nxt    = S_WAIT;
          exp_nxt   = {exp_r[EW-1:1], 1'b0};
        end else begin
          mul_start = 1'b1;
          mul_a     = base_r;
          ret_nxt   = S_PSQR;
          st_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mul_done) begin
          st_nxt = ret_r;
          case (ret_r)
            S_PMUL: acc_nxt = mul_p;
            S_PSQR: begin
              base_nxt = mul_p;
              exp_nxt  = exp_r >> 1;
              st_nxt   = S_PMUL;
            end
            S_FMUL: begin
              res_nxt = mul_p;
              st_nxt  = S_OUT;
            end
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_PSQR: st_nxt = S_PMUL;
      S_FMUL: st_nxt = S_OUT;
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    res_r  <= res_nxt;
    neg_r  <= neg_nxt;
    if (st_r == S_IDLE && in_start) begin
      mode_r  <= mode_t'(in_mode);
      b_raw_r <= in_operand_b;
    end
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ret_r <= S_IDLE;
    end else begin
      st_r  <= st_nxt;
      ret_r <= ret_nxt;
    end
  end

  assign in_busy    = (st_r != S_IDLE);
  assign out_valid  = (st_r == S_OUT);
  assign out_result = RES_W'(res_r);

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r)) else $error("state not one-hot");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_res_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (res_r < m)) else $error("result out of range");
  a_wait_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |=> st_r == S_WAIT) else $error("multiply not awaited");
endmodule
